/* rtl/core/bldc_hall_commutation_controller_core_assert.svh */
// Assertion macros used by the core module.
`ifndef BLDC_HALL_COMMUTATION_CONTROLLER_CORE_ASSERT_SVH
`define BLDC_HALL_COMMUTATION_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BHCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication, checked outside reset.
`define BHCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

/* rtl/core/bhcc_pkg.sv */
package bhcc_pkg;

    // register indexes on the config port
    localparam logic [2:0] REG_MAX_DUTY       = 3'd0;
    localparam logic [2:0] REG_RAMP_STEP      = 3'd1;
    localparam logic [2:0] REG_RAMP_INTERVAL  = 3'd2;
    localparam logic [2:0] REG_CURRENT_TRIP   = 3'd3;
    localparam logic [2:0] REG_FAULT_RETRY    = 3'd4;

    // reset values of the registers
    localparam logic [7:0]  RST_MAX_DUTY      = 8'd240;
    localparam logic [7:0]  RST_RAMP_STEP     = 8'd2;
    localparam logic [15:0] RST_RAMP_INTERVAL = 16'd10;
    localparam logic [9:0]  RST_CURRENT_TRIP  = 10'd650;
    localparam logic [15:0] RST_FAULT_RETRY   = 16'd1500;

    // status codes
    localparam logic [1:0] STATUS_DRIVE   = 2'd0;
    localparam logic [1:0] STATUS_FAULT   = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    // low-side phase codes
    localparam logic [1:0] PHASE_NONE = 2'd0;
    localparam logic [1:0] PHASE_A    = 2'd1;
    localparam logic [1:0] PHASE_B    = 2'd2;
    localparam logic [1:0] PHASE_C    = 2'd3;

    // high-side masks
    localparam logic [2:0] HIGH_A = 3'b100;
    localparam logic [2:0] HIGH_B = 3'b010;
    localparam logic [2:0] HIGH_C = 3'b001;

    typedef struct packed {
        logic       valid;
        logic [2:0] step;
        logic [2:0] high_mask;
        logic [1:0] low_phase;
    } t_hall_drive;

    // active-high hall pattern (A,B,C) to six-step drive
    function automatic t_hall_drive hall_to_drive(input logic [2:0] pattern);
        t_hall_drive d;
        d = '0;
        unique case (pattern)
            3'b101: d = '{1'b1, 3'd0, HIGH_A, PHASE_B};
            3'b100: d = '{1'b1, 3'd1, HIGH_A, PHASE_C};
            3'b110: d = '{1'b1, 3'd2, HIGH_B, PHASE_C};
            3'b010: d = '{1'b1, 3'd3, HIGH_B, PHASE_A};
            3'b011: d = '{1'b1, 3'd4, HIGH_C, PHASE_A};
            3'b001: d = '{1'b1, 3'd5, HIGH_C, PHASE_B};
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/bldc_hall_commutation_controller_core.sv */
// Throughput: one word per cycle while the master side takes words; input
// register, then one decision stage that updates fault/ramp state and loads
// the output register.
// Stalls on the master side back up through both registers.
// Reset (synchronous, active low) empties the pipeline, clears fault and ramp
// state and returns the config registers to their defaults.
`include "bldc_hall_commutation_controller_core_assert.svh"

module bldc_hall_commutation_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] now_ms, [32] kill_n, [42:33] setpoint_adc, [52:43] current_adc,
    // [55:53] hall_a_samples, [58:56] hall_b_samples, [61:59] hall_c_samples
    input  logic [63:0] i_s_axis_tdata,
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] status, [4:2] high_side_mask, [6:5] low_side_phase,
    // [14:7] low_side_duty, [17:15] commutation_step
    output logic [23:0] o_m_axis_tdata,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config registers
    logic [7:0]  r_max_duty;
    logic [7:0]  r_ramp_step;
    logic [15:0] r_ramp_interval;
    logic [9:0]  r_current_trip;
    logic [15:0] r_fault_retry;

    logic [2:0]  w_reg_idx;
    logic        w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty      <= bhcc_pkg::RST_MAX_DUTY;
            r_ramp_step     <= bhcc_pkg::RST_RAMP_STEP;
            r_ramp_interval <= bhcc_pkg::RST_RAMP_INTERVAL;
            r_current_trip  <= bhcc_pkg::RST_CURRENT_TRIP;
            r_fault_retry   <= bhcc_pkg::RST_FAULT_RETRY;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                bhcc_pkg::REG_MAX_DUTY:      r_max_duty      <= pwdata[7:0];
                bhcc_pkg::REG_RAMP_STEP:     r_ramp_step     <= pwdata[7:0];
                bhcc_pkg::REG_RAMP_INTERVAL: r_ramp_interval <= pwdata[15:0];
                bhcc_pkg::REG_CURRENT_TRIP:  r_current_trip  <= pwdata[9:0];
                bhcc_pkg::REG_FAULT_RETRY:   r_fault_retry   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            bhcc_pkg::REG_MAX_DUTY:      prdata = {24'd0, r_max_duty};
            bhcc_pkg::REG_RAMP_STEP:     prdata = {24'd0, r_ramp_step};
            bhcc_pkg::REG_RAMP_INTERVAL: prdata = {16'd0, r_ramp_interval};
            bhcc_pkg::REG_CURRENT_TRIP:  prdata = {22'd0, r_current_trip};
            bhcc_pkg::REG_FAULT_RETRY:   prdata = {16'd0, r_fault_retry};
            default:                     prdata = 32'd0;
        endcase
    end

    // pipeline control
    logic        r_in_valid;
    logic [61:0] r_in_data;
    logic        r_out_valid;
    logic [23:0] r_out_data;
    logic        w_out_adv;
    logic        w_in_take;
    logic        w_proc;

    assign w_out_adv       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_out_adv;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_proc          = r_in_valid && w_out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_data <= i_s_axis_tdata[61:0];
        end
    end

    // unpack the held word
    logic [31:0] w_now;
    logic        w_kill_n;
    logic [9:0]  w_setpoint;
    logic [9:0]  w_current;

    assign w_now      = r_in_data[31:0];
    assign w_kill_n   = r_in_data[32];
    assign w_setpoint = r_in_data[42:33];
    assign w_current  = r_in_data[52:43];

    bhcc_pkg::t_hall_drive w_drive;

    bhcc_hall_decode u_hall_decode (
        .i_hall_a_samples (r_in_data[55:53]),
        .i_hall_b_samples (r_in_data[58:56]),
        .i_hall_c_samples (r_in_data[61:59]),
        .o_drive          (w_drive)
    );

    // fault and ramp state
    logic        r_fault_latched;
    logic [31:0] r_fault_start;
    logic [7:0]  r_duty_now;
    logic [31:0] r_last_ramp;

    logic        w_trip;
    logic        w_fault;
    logic [31:0] w_fault_start;
    logic [31:0] w_fault_age;
    logic        w_hold;
    logic [31:0] w_ramp_age;
    logic        w_ramp_due;
    logic [7:0]  w_target;
    logic [8:0]  w_up;
    logic [8:0]  w_tgt_plus;
    logic [7:0]  n_duty_now;
    logic [23:0] n_out_data;

    assign w_trip        = !w_kill_n || (w_current >= r_current_trip);
    assign w_fault       = w_trip || r_fault_latched;
    assign w_fault_start = w_trip ? w_now : r_fault_start;
    assign w_fault_age   = w_now - w_fault_start;
    assign w_hold        = w_fault && !(w_fault_age > {16'd0, r_fault_retry});
    assign w_ramp_age    = w_now - r_last_ramp;
    assign w_ramp_due    = !w_hold && (w_ramp_age >= {16'd0, r_ramp_interval});

    assign w_target   = (w_setpoint[9:2] > r_max_duty) ? r_max_duty : w_setpoint[9:2];
    assign w_up       = {1'b0, r_duty_now} + {1'b0, r_ramp_step};
    assign w_tgt_plus = {1'b0, w_target} + {1'b0, r_ramp_step};

    always_comb begin
        priority if (!w_ramp_due) begin
            n_duty_now = r_duty_now;
        end else if (r_duty_now < w_target) begin
            n_duty_now = (w_up < {1'b0, w_target}) ? w_up[7:0] : w_target;
        end else if (r_duty_now > w_target) begin
            n_duty_now = ({1'b0, r_duty_now} > w_tgt_plus) ? r_duty_now - r_ramp_step
                                                           : w_target;
        end else begin
            n_duty_now = r_duty_now;
        end
    end

    always_comb begin
        n_out_data = '0;
        priority if (w_hold) begin
            n_out_data[1:0] = bhcc_pkg::STATUS_FAULT;
        end else if (!w_drive.valid) begin
            n_out_data[1:0] = bhcc_pkg::STATUS_INVALID;
        end else begin
            n_out_data[1:0]   = bhcc_pkg::STATUS_DRIVE;
            n_out_data[4:2]   = w_drive.high_mask;
            n_out_data[6:5]   = w_drive.low_phase;
            n_out_data[14:7]  = n_duty_now;
            n_out_data[17:15] = w_drive.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_latched <= 1'b0;
            r_fault_start   <= '0;
            r_duty_now      <= '0;
            r_last_ramp     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_proc) begin
                r_fault_latched <= w_hold;
                r_fault_start   <= w_fault_start;
                r_duty_now      <= n_duty_now;
                if (w_ramp_due) begin
                    r_last_ramp <= w_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // a fault word drives no gate
    `BHCC_ASSERT_NOW(a_fault_off, i_clk, i_rst_n,
        r_out_valid && r_out_data[1:0] == bhcc_pkg::STATUS_FAULT, r_out_data[23:2] == 22'd0)
    // a driving word has exactly one high side and a low-side phase
    `BHCC_ASSERT_NOW(a_drive_shape, i_clk, i_rst_n,
        r_out_valid && r_out_data[1:0] == bhcc_pkg::STATUS_DRIVE,
        $onehot(r_out_data[4:2]) && r_out_data[6:5] != bhcc_pkg::PHASE_NONE)
    // ramp state only moves when a word is processed
    `BHCC_ASSERT_NEXT(a_duty_idle, i_clk, i_rst_n, !w_proc,
        $stable(r_duty_now) && $stable(r_last_ramp))

endmodule

/* rtl/core/bhcc_hall_decode.sv */
module bhcc_hall_decode (
    input  logic [2:0]           i_hall_a_samples,
    input  logic [2:0]           i_hall_b_samples,
    input  logic [2:0]           i_hall_c_samples,
    output bhcc_pkg::t_hall_drive o_drive
);

    // lines are active low: a line is asserted when most samples are low
    function automatic logic hall_level(input logic [2:0] s);
        return !((s[0] & s[1]) | (s[0] & s[2]) | (s[1] & s[2]));
    endfunction

    logic [2:0] w_pattern;

    assign w_pattern = {hall_level(i_hall_a_samples), hall_level(i_hall_b_samples),
                        hall_level(i_hall_c_samples)};
    assign o_drive   = bhcc_pkg::hall_to_drive(w_pattern);

endmodule
